// ----- hdl/bdac_pkg.sv -----
// Package for the binary to decimal ASCII core.
// Holds widths, ASCII codes, controller state encoding and the
// command/status structs shared by the controller and datapath.
package bdac_pkg;

  localparam int VALUE_W     = 64;
  localparam int NUM_DIGITS  = 20;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int DIGIT_IDX_W = 5;
  localparam int STEP_W      = 6;
  localparam int CHAR_W      = 8;

  localparam logic [DIGIT_IDX_W-1:0] TOP_DIGIT = DIGIT_IDX_W'(NUM_DIGITS - 1);
  localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(VALUE_W - 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'd10;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_NL   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic dec_idx;
    logic emit_digit;
    logic emit_nl;
  } cmd_t;

  typedef struct packed {
    logic shift_last;
    logic digit_zero;
    logic idx_zero;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/bdac_ctrl.sv -----
// Controller for the binary to decimal ASCII core.
// Sequences load, double-dabble conversion, leading-zero skip and
// character emission. Depends on bdac_pkg.
module bdac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bdac_pkg::status_t status,
  output bdac_pkg::cmd_t    cmd
);
  import bdac_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.shift_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (status.digit_zero && !status.idx_zero) begin
          cmd.dec_idx = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.idx_zero) begin
            state_next = ST_NL;
          end else begin
            cmd.dec_idx = 1'b1;
          end
        end
      end
      ST_NL: begin
        if (status.out_free) begin
          cmd.emit_nl = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/bdac_datapath.sv -----
// Datapath for the binary to decimal ASCII core.
// Binary and BCD shift registers, digit pointer, step counter and the
// output register. Depends on bdac_pkg.
module bdac_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bdac_pkg::VALUE_W-1:0]   value,
  input  bdac_pkg::cmd_t                 cmd,
  output bdac_pkg::status_t              status,
  output logic                           char_valid,
  input  logic                           char_stall,
  output logic [bdac_pkg::CHAR_W-1:0]    character,
  output logic                           last_of_run
);
  import bdac_pkg::*;

  logic [VALUE_W-1:0]     bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [DIGIT_IDX_W-1:0] idx;
  logic [STEP_W-1:0]      step;
  logic [3:0]             digit;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  assign digit = bcd[{idx, 2'b00} +: 4];

  assign status.shift_last = (step == LAST_STEP);
  assign status.digit_zero = (digit == 4'd0);
  assign status.idx_zero   = (idx == '0);
  assign status.out_free   = !char_valid || !char_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin  <= value;
      bcd  <= '0;
      step <= '0;
      idx  <= TOP_DIGIT;
    end else begin
      if (cmd.shift) begin
        bin  <= {bin[VALUE_W-2:0], 1'b0};
        bcd  <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
        step <= step + STEP_W'(1);
      end
      if (cmd.dec_idx) begin
        idx <= idx - DIGIT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.emit_digit || cmd.emit_nl) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      character   <= ASCII_ZERO + {4'b0000, digit};
      last_of_run <= 1'b0;
    end else if (cmd.emit_nl) begin
      character   <= ASCII_NEWLINE;
      last_of_run <= 1'b1;
    end
  end

endmodule

// ----- hdl/binary_to_decimal_ascii_core.sv -----
// Binary to decimal ASCII core: top level.
// Takes an unsigned 64-bit number and streams its decimal digits, most
// significant first and without leading zeros, then a newline carrying
// last_of_run. Zero prints as a single '0'.
//
// Input channel: item_valid / item_stall with payload value. A beat is
// taken when item_valid is high and item_stall is low. One number is
// worked at a time; item_stall is low only while the core is idle.
// Output channel: char_valid / char_stall with character and
// last_of_run, driven from an output register.
//
// Steps per number: load, 64 double-dabble steps (one bit a cycle
// through the BCD shift register), then the skip state steps the digit
// pointer past each leading zero digit, then one character per cycle
// while the receiver does not stall: 2 to 21 beats. A stall holds the
// output register and the controller until the beat is taken; the next
// number is accepted while the newline beat still waits.
// Reset (rst, synchronous) returns the controller to idle and drops
// char_valid.
module binary_to_decimal_ascii_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [bdac_pkg::VALUE_W-1:0]  value,
  output logic                          char_valid,
  input  logic                          char_stall,
  output logic [bdac_pkg::CHAR_W-1:0]   character,
  output logic                          last_of_run
);
  import bdac_pkg::*;

  cmd_t    cmd;
  status_t status;

  bdac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  bdac_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .character   (character),
    .last_of_run (last_of_run)
  );

endmodule

// ----- tb/decimal_text_checker.sv -----
// Checker for the binary to decimal ASCII core: watches the value and character channels,
// works out the decimal text of every accepted number and compares each character beat.
// Depends on bdac_pkg for widths and ASCII codes.
`timescale 1ns / 1ps

module decimal_text_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  logic [bdac_pkg::VALUE_W-1:0] value,
  input  logic                         char_valid,
  input  logic                         char_stall,
  input  logic [bdac_pkg::CHAR_W-1:0]  character,
  input  logic                         last_of_run,
  output int                           failures,
  output int                           pending
);
  import bdac_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              ends_line;
  } text_beat_t;

  text_beat_t expected_text[$];
  int fail_count = 0;
  int queued = 0;

  assign failures = fail_count;
  assign pending  = queued;

  // decimal digits, most significant first, then the newline
  function automatic void predict_decimal(input logic [VALUE_W-1:0] num);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         digs[NUM_DIGITS];
    int                 count;
    text_beat_t         beat;
    rest  = num;
    count = 0;
    do begin
      digs[count] = 4'(rest % 64'd10);
      rest        = rest / 64'd10;
      count++;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      beat.code      = ASCII_ZERO + CHAR_W'(digs[k]);
      beat.ends_line = 1'b0;
      expected_text.push_back(beat);
    end
    beat.code      = ASCII_NEWLINE;
    beat.ends_line = 1'b1;
    expected_text.push_back(beat);
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst) begin
      if (item_valid && !item_stall) predict_decimal(value);
      if (char_valid && !char_stall) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character beat: character %0d last_of_run %0b",
                 character, last_of_run);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (character !== want.code) begin
            $error("character: expected %0d, actual %0d", want.code, character);
            fail_count++;
          end
          if (last_of_run !== want.ends_line) begin
            $error("last_of_run: expected %0b, actual %0b", want.ends_line, last_of_run);
            fail_count++;
          end
        end
      end
      queued = expected_text.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the testbench for binary_to_decimal_ascii_core: clock, reset, number stimulus
// and receiver stalls; decimal_text_checker does the prediction and comparison.
// Depends on bdac_pkg and decimal_text_checker.
`timescale 1ns / 1ps

module tb_top;
  import bdac_pkg::*;

  localparam int RANDOM_ITEMS = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [VALUE_W-1:0] value = '0;
  logic               char_valid;
  logic               char_stall = 1'b0;
  logic [CHAR_W-1:0]  character;
  logic               last_of_run;
  int                 failures;
  int                 pending;
  bit                 quiet = 1'b0;

  always #4 clk = ~clk;

  binary_to_decimal_ascii_core DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .character   (character),
    .last_of_run (last_of_run)
  );

  decimal_text_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .value       (value),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .character   (character),
    .last_of_run (last_of_run),
    .failures    (failures),
    .pending     (pending)
  );

  always @(posedge clk) char_stall <= !quiet && ($urandom_range(99) < 14);

  task automatic send_value(input logic [VALUE_W-1:0] num);
    item_valid <= 1'b1;
    value      <= num;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every expected character beat has been seen
  task automatic drain_text();
    idle_cycles(1);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] num;
    logic [VALUE_W-1:0] pow;
    int                 mode;
    int                 width;
    num  = {$urandom, $urandom};
    mode = $urandom_range(9);
    if (mode < 4) return num;
    if (mode < 7) begin
      width = $urandom_range(1, VALUE_W);
      return num >> (VALUE_W - width);
    end
    if (mode < 9) begin
      pow = 64'd1;
      repeat ($urandom_range(0, NUM_DIGITS - 1)) pow = pow * 64'd10;
      return pow + 64'($urandom_range(0, 2)) - 64'd1;
    end
    return 64'($urandom_range(0, 20));
  endfunction

  logic [VALUE_W-1:0] directed[] = '{
    64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
    64'd10000000000000000000, 64'd9999999999999999999,
    64'd1000000000000000000, 64'd999999999999999999,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'd12345678901234567890, 64'd7
  };

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_value(directed[i]);
    drain_text();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 150 && i < 230);
      if (!quiet && $urandom_range(99) < 14) idle_cycles($urandom_range(1, 120));
      send_value(random_value());
      if (i == 300) drain_text();
    end
    quiet = 1'b0;
    drain_text();
    repeat (100) @(posedge clk);
    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- binary_to_decimal_ascii_core.f -----
hdl/bdac_pkg.sv
hdl/bdac_ctrl.sv
hdl/bdac_datapath.sv
hdl/binary_to_decimal_ascii_core.sv
tb/decimal_text_checker.sv
tb/tb_top.sv
